[sv/gsm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gsm_pkg
// shared types and codes for the generational slot map
// ----------------------------------------------------------------------------
package gsm_pkg;

  // fixed port field widths
  localparam int unsigned IN_INDEX_W   = 16;
  localparam int unsigned IN_GEN_W     = 16;
  localparam int unsigned IN_PAYLOAD_W = 32;
  localparam int unsigned OUT_INDEX_W  = 6;
  localparam int unsigned OUT_GEN_W    = 16;
  localparam int unsigned OUT_REMOVE_W = 32;

  // command queue depth between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  localparam logic ACT_REGISTER   = 1'b0;
  localparam logic ACT_UNREGISTER = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  // classified command as it travels through the queue
  typedef struct packed {
    logic                      unreg;
    logic                      in_range;
    logic [IN_INDEX_W-1:0]     index;
    logic [IN_GEN_W-1:0]       gen;
    logic [IN_PAYLOAD_W-1:0]   payload;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic                      valid;
    status_t                   status;
    logic [OUT_INDEX_W-1:0]    index;
    logic [OUT_GEN_W-1:0]      gen;
    logic [OUT_REMOVE_W-1:0]   removed;
  } res_t;

endpackage
`default_nettype wire

[sv/generational_slot_map_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// generational_slot_map_top
// handle allocator: slot indices with generation counts over a packed payload array
// ----------------------------------------------------------------------------
// results: a register strobes from S_R_GEN, an unregister past the generation check
//   from S_U_FETCH, a stale generation from S_U_LOOK, a full table or bad index
//   from S_IDLE; the back end runs one item at a time: the pop, then two dependent
//   memory reads, only the first on a stale generation, none on an early reject
// reset: a clearing pass over all MAX_ENTRIES slots zeroes generations and refills
//   the free stack in identity order with busy high; the receiver cannot stall
// ----------------------------------------------------------------------------
module generational_slot_map_top import gsm_pkg::*; #(
  parameter int unsigned MAX_ENTRIES  = 64,
  parameter int unsigned GEN_BITS     = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // command side
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    in_action,
  input  wire logic [IN_PAYLOAD_W-1:0] in_payload,
  input  wire logic [IN_INDEX_W-1:0]   in_handle_index,
  input  wire logic [IN_GEN_W-1:0]     in_handle_gen,
  // result side
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [OUT_INDEX_W-1:0]       out_index,
  output logic [OUT_GEN_W-1:0]         out_gen,
  output logic [OUT_REMOVE_W-1:0]      out_removed_payload
);

  // front to queue
  logic   push;
  op_t    fe_op;
  // queue to back
  op_t    q_op;
  qstat_t qstat;
  logic   pop;
  // back status
  logic   clearing;
  res_t   res;

  // front: take the item, decode action and range-check the index
  gsm_front #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start_i        (start),
    .action_i       (in_action),
    .payload_i      (in_payload),
    .handle_index_i (in_handle_index),
    .handle_gen_i   (in_handle_gen),
    .clearing_i     (clearing),
    .qstat_i        (qstat),
    .busy_o         (busy),
    .push_o         (push),
    .op_o           (fe_op)
  );

  // short queue so the front keeps taking items while the back is at work
  gsm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .op_i    (fe_op),
    .pop_i   (pop),
    .op_o    (q_op),
    .qstat_o (qstat)
  );

  // back: owns the stores and runs one item at a time
  gsm_back #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .GEN_BITS     (GEN_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat_i    (qstat),
    .op_i       (q_op),
    .pop_o      (pop),
    .clearing_o (clearing),
    .res_o      (res)
  );

  // result registers live in the back end; just fan them out
  assign out_valid           = res.valid;
  assign out_status          = res.status;
  assign out_index           = res.index;
  assign out_gen             = res.gen;
  assign out_removed_payload = res.removed;

endmodule
`default_nettype wire

[sv/gsm_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gsm_front
// takes commands, decodes the action and range-checks the handle index
// ----------------------------------------------------------------------------
module gsm_front import gsm_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start_i,
  input  wire logic                    action_i,
  input  wire logic [IN_PAYLOAD_W-1:0] payload_i,
  input  wire logic [IN_INDEX_W-1:0]   handle_index_i,
  input  wire logic [IN_GEN_W-1:0]     handle_gen_i,
  input  wire logic                    clearing_i,
  input  wire qstat_t                  qstat_i,
  output logic                         busy_o,
  output logic                         push_o,
  output op_t                          op_o
);

  logic fe_valid_r;
  logic fe_valid_nxt;
  op_t  fe_op_r;
  logic take;

  assign busy_o = clearing_i | (fe_valid_r & qstat_i.full);
  assign take   = start_i & ~busy_o;
  assign push_o = fe_valid_r & ~qstat_i.full;
  assign op_o   = fe_op_r;

  always_comb begin
    fe_valid_nxt = fe_valid_r;
    if (take) begin
      fe_valid_nxt = 1'b1;
    end else if (push_o) begin
      fe_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_valid_r <= 1'b0;
    end else begin
      fe_valid_r <= fe_valid_nxt;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      fe_op_r.unreg    <= (action_i == ACT_UNREGISTER);
      fe_op_r.in_range <= ({1'b0, handle_index_i} < (IN_INDEX_W+1)'(MAX_ENTRIES));
      fe_op_r.index    <= handle_index_i;
      fe_op_r.gen      <= handle_gen_i;
      fe_op_r.payload  <= payload_i;
    end
  end

endmodule
`default_nettype wire

[sv/gsm_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gsm_queue
// short command queue decoupling the front from the back
// ----------------------------------------------------------------------------
module gsm_queue import gsm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_i,
  input  wire op_t  op_i,
  input  wire logic pop_i,
  output op_t       op_o,
  output qstat_t    qstat_o
);

  op_t               mem [QDEPTH];
  logic [QPTR_W-1:0] head_r;
  logic [QPTR_W-1:0] tail_r;
  logic [QCNT_W-1:0] count_r;

  assign qstat_o.full  = (count_r == QCNT_W'(QDEPTH));
  assign qstat_o.empty = (count_r == '0);
  assign op_o          = mem[head_r];

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem[tail_r] <= op_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (push_i) begin
        tail_r <= tail_r + 1'b1;
      end
      if (pop_i) begin
        head_r <= head_r + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !qstat_o.full) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !qstat_o.empty) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH)) else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

[sv/gsm_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gsm_back
// executes register and unregister commands against the slot and packed stores
// ----------------------------------------------------------------------------
module gsm_back import gsm_pkg::*; #(
  parameter int unsigned MAX_ENTRIES  = 64,
  parameter int unsigned GEN_BITS     = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire qstat_t qstat_i,
  input  wire op_t    op_i,
  output logic        pop_o,
  output logic        clearing_o,
  output res_t        res_o
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_R_SLOT,
    S_R_GEN,
    S_U_LOOK,
    S_U_FETCH
  } state_t;

  state_t                  state_r;
  logic [IDX_W-1:0]        clr_r;
  logic [CNT_W-1:0]        live_r;
  op_t                     op_r;
  logic [IDX_W-1:0]        slot_r;
  logic [IDX_W-1:0]        pos_r;
  logic [GEN_BITS-1:0]     gen_r;
  res_t                    res_r;

  // stores
  logic [IDX_W-1:0]        fs_mem  [MAX_ENTRIES];
  logic [GEN_BITS-1:0]     gen_mem [MAX_ENTRIES];
  logic [IDX_W-1:0]        pos_mem [MAX_ENTRIES];
  logic [IDX_W-1:0]        own_mem [MAX_ENTRIES];
  logic [PAYLOAD_BITS-1:0] pay_mem [MAX_ENTRIES];

  // registered read data
  logic [IDX_W-1:0]        fs_q;
  logic [GEN_BITS-1:0]     gen_q;
  logic [IDX_W-1:0]        pos_q;
  logic [IDX_W-1:0]        own_a_q;
  logic [IDX_W-1:0]        own_b_q;
  logic [PAYLOAD_BITS-1:0] pay_a_q;
  logic [PAYLOAD_BITS-1:0] pay_b_q;

  // port controls
  logic                    fs_we;
  logic [IDX_W-1:0]        fs_waddr, fs_wdata, fs_raddr;
  logic                    gen_we;
  logic [IDX_W-1:0]        gen_waddr, gen_raddr;
  logic [GEN_BITS-1:0]     gen_wdata;
  logic                    pos_we;
  logic [IDX_W-1:0]        pos_waddr, pos_wdata, pos_raddr;
  logic                    own_we;
  logic [IDX_W-1:0]        own_waddr, own_wdata, own_raddr_a, own_raddr_b;
  logic                    pay_we;
  logic [IDX_W-1:0]        pay_waddr, pay_raddr_a, pay_raddr_b;
  logic [PAYLOAD_BITS-1:0] pay_wdata;

  logic                    full;
  logic [IDX_W-1:0]        last;
  logic [IDX_W-1:0]        cur_slot;
  logic                    gen_match;
  logic                    commit_ok;
  logic                    moved;

  assign full       = (live_r == CNT_W'(MAX_ENTRIES));
  assign last       = IDX_W'(live_r - 1'b1);
  assign cur_slot   = IDX_W'(op_r.index);
  assign gen_match  = (32'(gen_q) == 32'(op_r.gen));
  assign commit_ok  = (CNT_W'(pos_r) < live_r) && (own_a_q == cur_slot);
  assign moved      = (pos_r != last);
  assign pop_o      = (state_r == S_IDLE) && !qstat_i.empty;
  assign clearing_o = (state_r == S_CLEAR);
  assign res_o      = res_r;

  always_comb begin
    fs_we       = 1'b0;
    fs_waddr    = '0;
    fs_wdata    = '0;
    fs_raddr    = IDX_W'(live_r);
    gen_we      = 1'b0;
    gen_waddr   = '0;
    gen_wdata   = '0;
    gen_raddr   = IDX_W'(op_i.index);
    pos_we      = 1'b0;
    pos_waddr   = '0;
    pos_wdata   = '0;
    pos_raddr   = IDX_W'(op_i.index);
    own_we      = 1'b0;
    own_waddr   = '0;
    own_wdata   = '0;
    own_raddr_a = pos_q;
    own_raddr_b = last;
    pay_we      = 1'b0;
    pay_waddr   = '0;
    pay_wdata   = '0;
    pay_raddr_a = pos_q;
    pay_raddr_b = last;
    unique case (state_r)
      S_CLEAR: begin
        fs_we     = 1'b1;
        fs_waddr  = clr_r;
        fs_wdata  = clr_r;
        gen_we    = 1'b1;
        gen_waddr = clr_r;
      end
      S_R_SLOT: begin
        // append at the packed tail and link both ways
        gen_raddr = fs_q;
        pos_we    = 1'b1;
        pos_waddr = fs_q;
        pos_wdata = IDX_W'(live_r);
        own_we    = 1'b1;
        own_waddr = IDX_W'(live_r);
        own_wdata = fs_q;
        pay_we    = 1'b1;
        pay_waddr = IDX_W'(live_r);
        pay_wdata = PAYLOAD_BITS'(op_r.payload);
      end
      S_U_FETCH: begin
        if (commit_ok) begin
          gen_we    = 1'b1;
          gen_waddr = cur_slot;
          gen_wdata = gen_r + 1'b1;
          fs_we     = 1'b1;
          fs_waddr  = last;
          fs_wdata  = cur_slot;
          if (moved) begin
            // last packed entry fills the gap
            pay_we    = 1'b1;
            pay_waddr = pos_r;
            pay_wdata = pay_b_q;
            own_we    = 1'b1;
            own_waddr = pos_r;
            own_wdata = own_b_q;
            pos_we    = 1'b1;
            pos_waddr = own_b_q;
            pos_wdata = pos_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fs_we) fs_mem[fs_waddr] <= fs_wdata;
    fs_q <= fs_mem[fs_raddr];
  end

  always_ff @(posedge clk) begin
    if (gen_we) gen_mem[gen_waddr] <= gen_wdata;
    gen_q <= gen_mem[gen_raddr];
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
    pos_q <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (own_we) own_mem[own_waddr] <= own_wdata;
    own_a_q <= own_mem[own_raddr_a];
    own_b_q <= own_mem[own_raddr_b];
  end

  always_ff @(posedge clk) begin
    if (pay_we) pay_mem[pay_waddr] <= pay_wdata;
    pay_a_q <= pay_mem[pay_raddr_a];
    pay_b_q <= pay_mem[pay_raddr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      live_r    <= '0;
      res_r     <= '0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          res_r.valid <= 1'b0;
          clr_r       <= clr_r + 1'b1;
          if (clr_r == IDX_W'(MAX_ENTRIES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!qstat_i.empty) begin
            op_r <= op_i;
            if (!op_i.unreg) begin
              if (full) begin
                res_r <= '{valid: 1'b1, status: ST_FULL, index: '0, gen: '0, removed: '0};
              end else begin
                res_r.valid <= 1'b0;
                state_r     <= S_R_SLOT;
              end
            end else if (!op_i.in_range) begin
              res_r <= '{valid: 1'b1, status: ST_BAD, index: '0, gen: '0, removed: '0};
            end else begin
              res_r.valid <= 1'b0;
              state_r     <= S_U_LOOK;
            end
          end else begin
            res_r.valid <= 1'b0;
          end
        end
        S_R_SLOT: begin
          res_r.valid <= 1'b0;
          slot_r      <= fs_q;
          live_r      <= live_r + 1'b1;
          state_r     <= S_R_GEN;
        end
        S_R_GEN: begin
          res_r   <= '{valid: 1'b1, status: ST_OK, index: OUT_INDEX_W'(slot_r),
                       gen: OUT_GEN_W'(gen_q), removed: '0};
          state_r <= S_IDLE;
        end
        S_U_LOOK: begin
          if (gen_match) begin
            res_r.valid <= 1'b0;
            pos_r       <= pos_q;
            gen_r       <= gen_q;
            state_r     <= S_U_FETCH;
          end else begin
            res_r   <= '{valid: 1'b1, status: ST_BAD, index: '0, gen: '0, removed: '0};
            state_r <= S_IDLE;
          end
        end
        S_U_FETCH: begin
          if (commit_ok) begin
            live_r <= live_r - 1'b1;
            res_r  <= '{valid: 1'b1, status: ST_OK, index: '0, gen: '0,
                        removed: OUT_REMOVE_W'(pay_a_q)};
          end else begin
            res_r  <= '{valid: 1'b1, status: ST_BAD, index: '0, gen: '0, removed: '0};
          end
          state_r <= S_IDLE;
        end
        default: begin
          res_r.valid <= 1'b0;
          state_r     <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= CNT_W'(MAX_ENTRIES)) else $error("live count beyond capacity");
  a_reg_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_R_SLOT) |=> (live_r == $past(live_r) + 1'b1))
    else $error("register did not grow live count");
  a_unreg_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_U_FETCH && commit_ok) |=> (live_r == $past(live_r) - 1'b1))
    else $error("unregister did not shrink live count");
  a_quiet_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !res_r.valid) else $error("result during clearing pass");
`endif

endmodule
`default_nettype wire

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// generational slot map testbench
// drives register and unregister items through the command port, predicts
// every result from a behavioural copy of the slot map state (free stack,
// packed array, slot links and generations) and checks each result strobe
// field by field against the oldest outstanding prediction
// ----------------------------------------------------------------------------
module testbench;
  import gsm_pkg::*;

  localparam int unsigned SLOTS          = 64;
  localparam int unsigned GAP_MAX        = 19;
  localparam int unsigned DRAIN_CYCLES   = 8;     // idle margin after the last result
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // clearing pass + gap + latency, many times over
  localparam int unsigned RANDOM_ITEMS   = 1000;
  localparam int unsigned REUSE_ROUNDS   = 24;

  // one predicted result item
  typedef struct packed {
    status_t     status;
    logic [5:0]  index;
    logic [15:0] gen;
    logic [31:0] removed;
  } slot_result_t;

  // dut ports, all inputs known from time zero
  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        start           = 1'b0;
  logic        in_action       = ACT_REGISTER;
  logic [31:0] in_payload      = '0;
  logic [15:0] in_handle_index = '0;
  logic [15:0] in_handle_gen   = '0;
  logic        busy;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [5:0]  out_index;
  logic [15:0] out_gen;
  logic [31:0] out_removed_payload;

  // predicted slot map state
  logic [15:0] gen_of_slot  [SLOTS];
  logic [5:0]  pos_of_slot  [SLOTS];
  logic [31:0] packed_pay   [SLOTS];
  logic [5:0]  packed_slot  [SLOTS];
  logic [5:0]  free_slots   [SLOTS];
  bit          slot_touched [SLOTS];  // slot link written at least once
  int unsigned live_count;

  slot_result_t pending_results[$];
  int unsigned  mismatches    = 0;
  int unsigned  quiet_cycles  = 0;
  bit           sender_idles  = 1'b1;

  generational_slot_map_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_action           (in_action),
    .in_payload          (in_payload),
    .in_handle_index     (in_handle_index),
    .in_handle_gen       (in_handle_gen),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_index           (out_index),
    .out_gen             (out_gen),
    .out_removed_payload (out_removed_payload)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // state after reset: generations zero, free stack in identity order
  function automatic void clear_slot_map();
    for (int unsigned i = 0; i < SLOTS; i++) begin
      gen_of_slot[i]  = '0;
      pos_of_slot[i]  = '0;
      packed_pay[i]   = '0;
      packed_slot[i]  = '0;
      free_slots[i]   = 6'(i);
      slot_touched[i] = 1'b0;
    end
    live_count = 0;
  endfunction

  // applies one accepted item to the predicted state and returns its result
  function automatic slot_result_t predict_slot_map(input logic act, input logic [31:0] pay,
                                                    input logic [15:0] idx,
                                                    input logic [15:0] gen);
    slot_result_t r;
    logic [5:0]   s;
    logic [5:0]   p;
    logic [5:0]   last;
    logic [5:0]   moved;
    r = '{status: ST_OK, index: '0, gen: '0, removed: '0};
    if (act == ACT_REGISTER) begin
      if (live_count >= SLOTS) begin
        r.status = ST_FULL;
      end else begin
        // pop the free stack, append at the end of the packed array
        s = free_slots[live_count];
        packed_pay[live_count]  = pay;
        packed_slot[live_count] = s;
        pos_of_slot[s]          = 6'(live_count);
        slot_touched[s]         = 1'b1;
        live_count++;
        r.index = s;
        r.gen   = gen_of_slot[s];
      end
    end else if (idx >= SLOTS) begin
      r.status = ST_BAD;
    end else begin
      s = idx[5:0];
      p = pos_of_slot[s];
      if (gen_of_slot[s] != gen || p >= live_count || packed_slot[p] != s) begin
        r.status = ST_BAD;
      end else begin
        r.removed      = packed_pay[p];
        gen_of_slot[s] = gen_of_slot[s] + 16'd1;
        last           = 6'(live_count - 1);
        // fill the gap with the last packed entry unless it is the gap itself
        if (p != last) begin
          moved              = packed_slot[last];
          packed_pay[p]      = packed_pay[last];
          packed_slot[p]     = moved;
          pos_of_slot[moved] = p;
        end
        live_count--;
        free_slots[live_count] = s;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
  endtask

  // results are sampled at the edge that ends their strobe cycle
  always @(posedge clk) begin : check_results
    slot_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing outstanding, status", 32'(out_status), '0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_index !== want.index)
          report_mismatch("index", 32'(out_index), 32'(want.index));
        if (out_gen !== want.gen)
          report_mismatch("generation", 32'(out_gen), 32'(want.gen));
        if (out_removed_payload !== want.removed)
          report_mismatch("removed payload", out_removed_payload, want.removed);
      end
    end
  end

  // watchdog: any accepted item or result strobe counts as progress
  always @(posedge clk) begin
    if ((rst_n && start && !busy) || out_valid === 1'b1) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // sends one item, optionally after a random idle gap; start is left high so
  // that a following item with no gap goes straight in
  task automatic send_command(input logic act, input logic [31:0] pay,
                              input logic [15:0] idx, input logic [15:0] gen);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(0, GAP_MAX) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_action       <= act;
    in_payload      <= pay;
    in_handle_index <= idx;
    in_handle_gen   <= gen;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_slot_map(act, pay, idx, gen));
  endtask

  // idle the sender until every outstanding result has come back
  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // payload with the extremes mixed in
  function automatic logic [31:0] pick_payload();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return 32'($urandom);
    endcase
  endfunction

  task automatic register_entry();
    send_command(ACT_REGISTER, pick_payload(), 16'($urandom), 16'($urandom));
  endtask

  // unregister a randomly chosen live handle
  task automatic unregister_live();
    logic [5:0] s;
    s = packed_slot[$urandom_range(0, live_count - 1)];
    send_command(ACT_UNREGISTER, 32'($urandom), 16'(s), gen_of_slot[s]);
  endtask

  // out of range index, wrong generation, or a freed slot with its own generation;
  // a slot whose link was never written only ever sees a wrong generation
  task automatic send_bad_handle();
    int unsigned kind;
    logic [5:0]  s;
    logic [15:0] g;
    kind = $urandom_range(0, 2);
    if (kind == 0) begin
      send_command(ACT_UNREGISTER, 32'($urandom), 16'($urandom_range(SLOTS, 65535)),
                   16'($urandom));
    end else begin
      s = 6'($urandom_range(0, SLOTS - 1));
      if (kind == 2 && live_count < SLOTS) s = free_slots[$urandom_range(live_count, SLOTS - 1)];
      g = gen_of_slot[s] ^ 16'($urandom_range(1, 65535));
      if (kind == 2 && live_count < SLOTS && slot_touched[s]) g = gen_of_slot[s];
      send_command(ACT_UNREGISTER, 32'($urandom), 16'(s), g);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // fresh table hands out slots 0, 1, 2 ... at generation zero
  task automatic test_issue_order();
    send_command(ACT_REGISTER, 32'h0000_0000, 16'hffff, 16'hffff);
    send_command(ACT_REGISTER, 32'hffff_ffff, 16'h0000, 16'h0000);
    send_command(ACT_REGISTER, 32'h5555_5555, 16'haaaa, 16'h5555);
    send_command(ACT_REGISTER, 32'haaaa_aaaa, 16'h5555, 16'haaaa);
    send_command(ACT_REGISTER, 32'h0000_0001, 16'h0001, 16'h8000);
    send_command(ACT_REGISTER, 32'h8000_0000, 16'h8000, 16'h0001);
  endtask

  // middle removal moves the last entry, last removal moves nothing,
  // and a freed slot comes back with its generation advanced
  task automatic test_removal_paths();
    send_command(ACT_UNREGISTER, 32'h1234_5678, 16'd1, gen_of_slot[1]);
    send_command(ACT_UNREGISTER, 32'h0, 16'd4, gen_of_slot[4]);
    send_command(ACT_UNREGISTER, 32'hffff_ffff, 16'd5, gen_of_slot[5]);
    send_command(ACT_REGISTER, 32'hdead_beef, 16'h0, 16'h0);
  endtask

  task automatic test_bad_handles();
    send_command(ACT_UNREGISTER, 32'h0, 16'd64, 16'h0000);
    send_command(ACT_UNREGISTER, 32'h0, 16'hffff, 16'hffff);
    // upper index bits set, low bits alias a live slot
    send_command(ACT_UNREGISTER, 32'h0, 16'h8002, gen_of_slot[2]);
    send_command(ACT_UNREGISTER, 32'h0, 16'd2, gen_of_slot[2] + 16'd1);
    send_command(ACT_UNREGISTER, 32'h0, 16'd2, gen_of_slot[2] ^ 16'h8000);
    // freed slot with its current generation is still not live
    send_command(ACT_UNREGISTER, 32'h0, 16'd4, gen_of_slot[4]);
    // stale handle from before the removal
    send_command(ACT_UNREGISTER, 32'h0, 16'd4, gen_of_slot[4] - 16'd1);
  endtask

  // fill the table, knock on it while full, then empty it in random order
  task automatic test_fill_and_drain();
    while (live_count < SLOTS) register_entry();
    register_entry();
    register_entry();
    wait_for_results();
    while (live_count > 0) unregister_live();
  endtask

  // mostly well-formed traffic with phases that swing the table between
  // empty and full, plus broken handles and stretches without idling
  task automatic test_random_traffic(input int unsigned n_items);
    bit          fill_phase;
    int unsigned roll;
    fill_phase = 1'b1;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 150 == 149) fill_phase = ~fill_phase;
      if (i % 100 == 0) sender_idles = ($urandom_range(0, 3) != 0);
      if (i % 400 == 399) wait_for_results();
      roll = $urandom_range(0, 99);
      if (roll < 15) send_bad_handle();
      else if (live_count == 0 || roll < (fill_phase ? 75 : 40)) register_entry();
      else unregister_live();
    end
    sender_idles = 1'b1;
  endtask

  // one slot taken and released again and again, back to back; older handles
  // to it stay dead while the current one still works
  task automatic test_slot_reuse();
    logic [5:0] s;
    if (live_count == SLOTS) unregister_live();
    sender_idles = 1'b0;
    s = free_slots[live_count];
    for (int unsigned i = 0; i < REUSE_ROUNDS; i++) begin
      send_command(ACT_REGISTER, 32'($urandom), 16'h0, 16'h0);
      send_command(ACT_UNREGISTER, 32'h0, 16'(s), gen_of_slot[s]);
    end
    sender_idles = 1'b1;
    register_entry();
    send_command(ACT_UNREGISTER, 32'h0, 16'(s), gen_of_slot[s] - 16'd1);
    send_command(ACT_UNREGISTER, 32'h0, 16'(s), gen_of_slot[s]);
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------

  initial begin
    clear_slot_map();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // let the clearing pass raise busy before the first item
    repeat (2) @(posedge clk);

    test_issue_order();
    test_removal_paths();
    test_bad_handles();
    wait_for_results();
    test_fill_and_drain();
    test_random_traffic(RANDOM_ITEMS);
    test_slot_reuse();

    wait_for_results();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
